/* rtl/cylproj_pkg.sv */
// Shared constants for the cylindrical projection unit: request opcodes,
// register indexes and reset values, and the elaboration-time constant builder.
// No dependencies.
package cylproj_pkg;

   localparam int CSR_DATA_W = 8;

   localparam logic OPC_FORWARD = 1'b0;
   localparam logic OPC_INVERSE = 1'b1;

   localparam logic CSR_ITER_LIMIT = 1'b0;
   localparam logic CSR_STEP_TOL   = 1'b1;

   localparam logic [CSR_DATA_W-1:0] ITER_LIMIT_RESET = 8'd100;
   localparam logic [CSR_DATA_W-1:0] STEP_TOL_RESET   = 8'd1;

   // Magnitude of num/den with fb fraction bits, rounded to nearest; the integer part is counted up to 4 only.
   // Only used on constants, so it runs at elaboration.
   function automatic logic [63:0] const_q(input logic [63:0] num, input logic [63:0] den,
                                           input int fb);
      logic [63:0] r;
      logic [63:0] ip;
      logic [63:0] frac;
      r    = num;
      ip   = '0;
      frac = '0;
      for (int i = 0; i < 4; i++) begin
         if (r >= den) begin
            r  = r - den;
            ip = ip + 64'd1;
         end
      end
      for (int i = 0; i < fb + 1; i++) begin
         r    = r << 1;
         frac = frac << 1;
         if (r >= den) begin
            r       = r - den;
            frac[0] = 1'b1;
         end
      end
      return (ip << fb) + ((frac + 64'd1) >> 1);
   endfunction

endpackage

/* rtl/cylproj_mul.sv */
// Fixed-point multiplier for the projection unit: 16-bit digits of one operand
// per cycle, then rounding half away from zero, shift and saturation.
// Standalone; instantiated by cylindrical_projection_unit.
module cylproj_mul #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 28
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [DATA_WIDTH-1:0] op_a,
   input  logic signed [DATA_WIDTH-1:0] op_b,
   output logic                         done,
   output logic signed [DATA_WIDTH-1:0] product
);

   localparam int DIG_W = 16;
   localparam int NDIG  = (DATA_WIDTH + DIG_W - 1) / DIG_W;
   localparam int PB_W  = NDIG * DIG_W;
   localparam int ACC_W = 2 * DATA_WIDTH;
   localparam int MAG_W = ACC_W - FRAC_BITS;
   localparam int CNT_W = $clog2(NDIG + 1);

   localparam logic [ACC_W-1:0] ROUND_ADD = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic [MAG_W-1:0] LIM_MAX   = MAG_W'({1'b0, {(DATA_WIDTH-1){1'b1}}});
   localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   logic                         busy_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic [DATA_WIDTH-1:0]        mag_a_ff;
   logic [PB_W-1:0]              mag_b_ff;
   logic                         neg_ff;
   logic [ACC_W-1:0]             acc_ff;
   logic                         done_ff;
   logic signed [DATA_WIDTH-1:0] product_ff;

   logic [DATA_WIDTH-1:0]        mag_a;
   logic [DATA_WIDTH-1:0]        mag_b;
   logic [DATA_WIDTH+DIG_W-1:0]  partial;
   logic [ACC_W-1:0]             rounded;
   logic [MAG_W-1:0]             mag_q;
   logic signed [DATA_WIDTH-1:0] sat_q;

   always_comb begin
      mag_a   = op_a[DATA_WIDTH-1] ? DATA_WIDTH'(-op_a) : DATA_WIDTH'(op_a);
      mag_b   = op_b[DATA_WIDTH-1] ? DATA_WIDTH'(-op_b) : DATA_WIDTH'(op_b);
      partial = mag_a_ff * mag_b_ff[PB_W-1 -: DIG_W];
      rounded = acc_ff + ROUND_ADD;
      mag_q   = rounded[ACC_W-1:FRAC_BITS];
      if (mag_q > LIM_MAX) begin
         sat_q = neg_ff ? SAT_MIN : SAT_MAX;
      end else begin
         sat_q = neg_ff ? -$signed(mag_q[DATA_WIDTH-1:0]) : $signed(mag_q[DATA_WIDTH-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            cnt_ff   <= CNT_W'(NDIG);
            mag_a_ff <= mag_a;
            mag_b_ff <= PB_W'(mag_b);
            neg_ff   <= op_a[DATA_WIDTH-1] ^ op_b[DATA_WIDTH-1];
            acc_ff   <= '0;
         end else if (busy_ff) begin
            if (cnt_ff != '0) begin
               // Most significant digit first, so the accumulator only shifts.
               acc_ff   <= (acc_ff << DIG_W) + ACC_W'(partial);
               mag_b_ff <= mag_b_ff << DIG_W;
               cnt_ff   <= cnt_ff - CNT_W'(1);
            end else begin
               product_ff <= sat_q;
               done_ff    <= 1'b1;
               busy_ff    <= 1'b0;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = product_ff;

endmodule

/* rtl/cylproj_div.sv */
// Restoring divider for the Newton correction: (|n| << FRAC_BITS) / |d|,
// one quotient bit per cycle, signed and saturated. A zero divisor counts as 1.
// Standalone; instantiated by cylindrical_projection_unit.
module cylproj_div #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 28
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [DATA_WIDTH-1:0] numer,
   input  logic signed [DATA_WIDTH-1:0] denom,
   output logic                         done,
   output logic signed [DATA_WIDTH-1:0] quot
);

   localparam int NQ_W  = DATA_WIDTH + FRAC_BITS;
   localparam int CNT_W = $clog2(NQ_W + 1);

   localparam logic [NQ_W-1:0] LIM_MAX = NQ_W'({1'b0, {(DATA_WIDTH-1){1'b1}}});
   localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   logic                         busy_ff;
   logic                         done_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic [NQ_W-1:0]              nq_ff;
   logic [DATA_WIDTH:0]          rem_ff;
   logic [DATA_WIDTH-1:0]        ud_ff;
   logic                         neg_ff;
   logic signed [DATA_WIDTH-1:0] quot_ff;

   logic [DATA_WIDTH-1:0]        mag_n;
   logic [DATA_WIDTH-1:0]        mag_d;
   logic [DATA_WIDTH:0]          rem_sh;
   logic                         q_bit;
   logic [DATA_WIDTH:0]          rem_in;
   logic signed [DATA_WIDTH-1:0] sat_q;

   always_comb begin
      mag_n  = numer[DATA_WIDTH-1] ? DATA_WIDTH'(-numer) : DATA_WIDTH'(numer);
      mag_d  = denom[DATA_WIDTH-1] ? DATA_WIDTH'(-denom) : DATA_WIDTH'(denom);
      rem_sh = {rem_ff[DATA_WIDTH-1:0], nq_ff[NQ_W-1]};
      q_bit  = rem_sh >= {1'b0, ud_ff};
      rem_in = q_bit ? rem_sh - {1'b0, ud_ff} : rem_sh;
      if (nq_ff > LIM_MAX) begin
         sat_q = neg_ff ? SAT_MIN : SAT_MAX;
      end else begin
         sat_q = neg_ff ? -$signed(nq_ff[DATA_WIDTH-1:0]) : $signed(nq_ff[DATA_WIDTH-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NQ_W);
            nq_ff   <= {mag_n, {FRAC_BITS{1'b0}}};
            rem_ff  <= '0;
            ud_ff   <= (mag_d == '0) ? DATA_WIDTH'(1) : mag_d;
            neg_ff  <= numer[DATA_WIDTH-1] ^ denom[DATA_WIDTH-1];
         end else if (busy_ff) begin
            if (cnt_ff != '0) begin
               // Dividend bits leave at the top while quotient bits enter below.
               nq_ff  <= {nq_ff[NQ_W-2:0], q_bit};
               rem_ff <= rem_in;
               cnt_ff <= cnt_ff - CNT_W'(1);
            end else begin
               quot_ff <= sat_q;
               done_ff <= 1'b1;
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

/* rtl/cylindrical_projection_unit.sv */
// Cylindrical map projection unit, top level: request/response channels,
// register port and the sequencer around one shared multiplier and divider.
// Depends on cylproj_pkg, cylproj_mul and cylproj_div.
//
// Usage: a request carries an opcode and two signed fixed-point coordinates.
// Forward requests return x = longitude and y = P(latitude); inverse requests
// return longitude = x and the latitude that solves P(lat) = y by Newton steps,
// with rsp_not_converged set when the iteration limit runs out first.
// Requests and responses use valid/ready; one request is processed at a time
// and req_ready is high only while the unit is idle.
// A forward request runs six multiplies on the shared multiplier.
// One Newton step runs nine multiplies and one divide on the restoring divider,
// so the work of an inverse request grows with the number of steps it needs.
// The response is held in registers until rsp_ready; the unit stays busy and
// takes no new request while the response waits.
// Reset clears the sequencer and loads iteration_limit = 100, step_tolerance = 1.
// Register writes take effect at once and are meant for an idle unit.
module cylindrical_projection_unit
   import cylproj_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 28
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_opcode,
   input  logic signed [DATA_WIDTH-1:0] req_coord_a,
   input  logic signed [DATA_WIDTH-1:0] req_coord_b,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_result_a,
   output logic signed [DATA_WIDTH-1:0] rsp_result_b,
   output logic                         rsp_not_converged,
   input  logic                         csr_wr_en,
   input  logic                         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   localparam logic signed [DATA_WIDTH-1:0] K1 =
      DATA_WIDTH'(const_q(64'd10148, 64'd10000, FRAC_BITS));
   localparam logic signed [DATA_WIDTH-1:0] K2 =
      DATA_WIDTH'(const_q(64'd23185, 64'd100000, FRAC_BITS));
   localparam logic signed [DATA_WIDTH-1:0] K3 =
      -DATA_WIDTH'(const_q(64'd14499, 64'd100000, FRAC_BITS));
   localparam logic signed [DATA_WIDTH-1:0] K4 =
      DATA_WIDTH'(const_q(64'd2406, 64'd100000, FRAC_BITS));
   localparam logic signed [DATA_WIDTH-1:0] D2 =
      DATA_WIDTH'(const_q(64'd115925, 64'd100000, FRAC_BITS));
   localparam logic signed [DATA_WIDTH-1:0] D3 =
      -DATA_WIDTH'(const_q(64'd101493, 64'd100000, FRAC_BITS));
   localparam logic signed [DATA_WIDTH-1:0] D4 =
      DATA_WIDTH'(const_q(64'd21654, 64'd100000, FRAC_BITS));
   localparam logic signed [DATA_WIDTH-1:0] MAXY =
      DATA_WIDTH'(const_q(64'd1790857183, 64'd1000000000, FRAC_BITS));
   localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL_GO, ST_MUL_WAIT, ST_RESIDUAL, ST_DIV_GO, ST_DIV_WAIT, ST_UPDATE, ST_RESP
   } state_type;

   // Steps of the polynomial program: P(t) first, then P'(t).
   typedef enum logic [3:0] {
      PS_T2, PS_T4, PS_S_K3, PS_S_K2, PS_S_K1, PS_POLY, PS_D3, PS_D2, PS_DERIV
   } prog_step_type;

   function automatic logic signed [DATA_WIDTH-1:0] sat_add(
      input logic signed [DATA_WIDTH-1:0] a, input logic signed [DATA_WIDTH-1:0] b,
      input logic sub);
      logic signed [DATA_WIDTH:0] s;
      s = sub ? ({a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b})
              : ({a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b});
      if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
         return s[DATA_WIDTH] ? SAT_MIN : SAT_MAX;
      end
      return s[DATA_WIDTH-1:0];
   endfunction

   state_type                    state_ff;
   prog_step_type                step_ff;
   logic                         opcode_ff;
   logic [CSR_DATA_W-1:0]        iter_limit_ff;
   logic [CSR_DATA_W-1:0]        step_tol_ff;
   logic [CSR_DATA_W-1:0]        iter_ff;
   logic signed [DATA_WIDTH-1:0] yt_ff;
   logic signed [DATA_WIDTH-1:0] yc_ff;
   logic signed [DATA_WIDTH-1:0] t2_ff;
   logic signed [DATA_WIDTH-1:0] t4_ff;
   logic signed [DATA_WIDTH-1:0] s_ff;
   logic signed [DATA_WIDTH-1:0] p_ff;
   logic signed [DATA_WIDTH-1:0] fd_ff;
   logic signed [DATA_WIDTH-1:0] f_ff;
   logic signed [DATA_WIDTH-1:0] corr_ff;
   logic                         rsp_valid_ff;
   logic signed [DATA_WIDTH-1:0] rsp_a_ff;
   logic signed [DATA_WIDTH-1:0] rsp_b_ff;
   logic                         rsp_nc_ff;

   logic signed [DATA_WIDTH-1:0] clamp_y;
   logic signed [DATA_WIDTH-1:0] mul_a;
   logic signed [DATA_WIDTH-1:0] mul_b;
   logic signed [DATA_WIDTH-1:0] addend;
   logic signed [DATA_WIDTH-1:0] step_val;
   logic                         mul_done;
   logic signed [DATA_WIDTH-1:0] mul_product;
   logic                         div_done;
   logic signed [DATA_WIDTH-1:0] div_quot;
   logic signed [DATA_WIDTH-1:0] yc_in;
   logic [DATA_WIDTH-1:0]        corr_mag;
   logic                         converged;
   logic [CSR_DATA_W-1:0]        iter_in;

   cylproj_mul #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (state_ff == ST_MUL_GO),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .done   (mul_done),
      .product(mul_product)
   );

   cylproj_div #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(state_ff == ST_DIV_GO),
      .numer(f_ff),
      .denom(fd_ff),
      .done (div_done),
      .quot (div_quot)
   );

   always_comb begin
      if (req_coord_b > MAXY) begin
         clamp_y = MAXY;
      end else if (req_coord_b < -MAXY) begin
         clamp_y = -MAXY;
      end else begin
         clamp_y = req_coord_b;
      end

      mul_a  = yc_ff;
      mul_b  = yc_ff;
      addend = '0;
      case (step_ff)
         PS_T2: begin
            mul_a = yc_ff;
            mul_b = yc_ff;
         end
         PS_T4: begin
            mul_a = t2_ff;
            mul_b = t2_ff;
         end
         PS_S_K3: begin
            mul_a  = K4;
            mul_b  = t2_ff;
            addend = K3;
         end
         PS_S_K2: begin
            mul_a  = t2_ff;
            mul_b  = s_ff;
            addend = K2;
         end
         PS_S_K1: begin
            mul_a  = t4_ff;
            mul_b  = s_ff;
            addend = K1;
         end
         PS_POLY: begin
            mul_a = yc_ff;
            mul_b = s_ff;
         end
         PS_D3: begin
            mul_a  = D4;
            mul_b  = t2_ff;
            addend = D3;
         end
         PS_D2: begin
            mul_a  = t2_ff;
            mul_b  = s_ff;
            addend = D2;
         end
         PS_DERIV: begin
            mul_a  = t4_ff;
            mul_b  = s_ff;
            addend = K1;
         end
         default: begin
            mul_a  = yc_ff;
            mul_b  = yc_ff;
            addend = '0;
         end
      endcase
      step_val = sat_add(mul_product, addend, 1'b0);

      yc_in     = sat_add(yc_ff, corr_ff, 1'b1);
      corr_mag  = corr_ff[DATA_WIDTH-1] ? DATA_WIDTH'(-corr_ff) : DATA_WIDTH'(corr_ff);
      converged = corr_mag < DATA_WIDTH'(step_tol_ff);
      iter_in   = iter_ff + CSR_DATA_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= PS_T2;
         rsp_valid_ff  <= 1'b0;
         iter_limit_ff <= ITER_LIMIT_RESET;
         step_tol_ff   <= STEP_TOL_RESET;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_ITER_LIMIT) begin
               iter_limit_ff <= csr_wdata;
            end else begin
               step_tol_ff <= csr_wdata;
            end
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  opcode_ff <= req_opcode;
                  rsp_a_ff  <= req_coord_a;
                  iter_ff   <= '0;
                  step_ff   <= PS_T2;
                  yt_ff     <= clamp_y;
                  if (req_opcode == OPC_FORWARD) begin
                     yc_ff    <= req_coord_b;
                     state_ff <= ST_MUL_GO;
                  end else if (iter_limit_ff == '0) begin
                     // No iterations allowed: answer the clamped y unconverged.
                     rsp_b_ff     <= clamp_y;
                     rsp_nc_ff    <= 1'b1;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_RESP;
                  end else begin
                     yc_ff    <= clamp_y;
                     state_ff <= ST_MUL_GO;
                  end
               end
            end
            ST_MUL_GO: begin
               state_ff <= ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
               if (mul_done) begin
                  state_ff <= ST_MUL_GO;
                  case (step_ff)
                     PS_T2: begin
                        t2_ff   <= step_val;
                        step_ff <= PS_T4;
                     end
                     PS_T4: begin
                        t4_ff   <= step_val;
                        step_ff <= PS_S_K3;
                     end
                     PS_S_K3: begin
                        s_ff    <= step_val;
                        step_ff <= PS_S_K2;
                     end
                     PS_S_K2: begin
                        s_ff    <= step_val;
                        step_ff <= PS_S_K1;
                     end
                     PS_S_K1: begin
                        s_ff    <= step_val;
                        step_ff <= PS_POLY;
                     end
                     PS_POLY: begin
                        p_ff    <= step_val;
                        step_ff <= PS_D3;
                        if (opcode_ff == OPC_FORWARD) begin
                           rsp_b_ff     <= step_val;
                           rsp_nc_ff    <= 1'b0;
                           rsp_valid_ff <= 1'b1;
                           state_ff     <= ST_RESP;
                        end
                     end
                     PS_D3: begin
                        s_ff    <= step_val;
                        step_ff <= PS_D2;
                     end
                     PS_D2: begin
                        s_ff    <= step_val;
                        step_ff <= PS_DERIV;
                     end
                     PS_DERIV: begin
                        fd_ff    <= step_val;
                        step_ff  <= PS_T2;
                        state_ff <= ST_RESIDUAL;
                     end
                     default: begin
                        step_ff  <= PS_T2;
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_RESIDUAL: begin
               f_ff     <= sat_add(p_ff, yt_ff, 1'b1);
               state_ff <= ST_DIV_GO;
            end
            ST_DIV_GO: begin
               state_ff <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (div_done) begin
                  corr_ff  <= div_quot;
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               yc_ff   <= yc_in;
               iter_ff <= iter_in;
               step_ff <= PS_T2;
               if (converged || (iter_in == iter_limit_ff)) begin
                  rsp_b_ff     <= yc_in;
                  rsp_nc_ff    <= !converged;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_RESP;
               end else begin
                  state_ff <= ST_MUL_GO;
               end
            end
            ST_RESP: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_a      = rsp_a_ff;
   assign rsp_result_b      = rsp_b_ff;
   assign rsp_not_converged = rsp_nc_ff;

endmodule

/* tb/tb_cylindrical_projection_unit.sv */
// Self-checking testbench for cylindrical_projection_unit: random and directed
// forward and inverse requests checked against an in-bench fixed-point predictor.
// Depends on cylproj_pkg and the unit's RTL.
module tb_cylindrical_projection_unit
   import cylproj_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW = 32;
   localparam int FB = 28;
   localparam longint WMAX = 64'sd2147483647;
   localparam longint WMIN = -64'sd2147483648;
   localparam longint CYCLE_LIMIT = 40000000;

   typedef struct packed {
      logic                 opcode;
      logic signed [DW-1:0] coord_a;
      logic signed [DW-1:0] coord_b;
   } point_req_type;

   typedef struct packed {
      logic signed [DW-1:0] res_a;
      logic signed [DW-1:0] res_b;
      logic                 flag;
   } point_rsp_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_opcode;
   logic signed [DW-1:0] req_coord_a;
   logic signed [DW-1:0] req_coord_b;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic signed [DW-1:0] rsp_result_a;
   logic signed [DW-1:0] rsp_result_b;
   logic                 rsp_not_converged;
   logic                 csr_wr_en;
   logic                 csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   point_req_type pending_q[$];
   point_rsp_type projected_q[$];
   int         n_queued;
   int         n_accepted;
   int         n_errors;
   longint     n_cycles;
   bit         req_taken;
   bit         no_idle;
   bit         hold_req;
   int         hold_left;
   logic [7:0] iter_max;
   logic [7:0] step_tol;

   cylindrical_projection_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_coord_a(req_coord_a), .req_coord_b(req_coord_b),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_result_a(rsp_result_a),
      .rsp_result_b(rsp_result_b), .rsp_not_converged(rsp_not_converged),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------- fixed-point predictor ----------------
   function automatic longint clamp_w(longint v);
      if (v > WMAX) return WMAX;
      if (v < WMIN) return WMIN;
      return v;
   endfunction

   function automatic longint signed_mag(bit neg, longint unsigned m);
      if (m > longint'(WMAX)) return neg ? WMIN : WMAX;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint unsigned abs_w(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
   endfunction

   // Product rounded half away from zero, then saturated.
   function automatic longint fx_mul(longint a, longint b);
      longint unsigned p;
      p = abs_w(a) * abs_w(b) + (64'd1 << (FB - 1));
      return signed_mag((a < 0) != (b < 0), p >> FB);
   endfunction

   function automatic longint fx_div(longint n, longint d);
      longint unsigned ud;
      ud = abs_w(d);
      if (ud == 0) ud = 1;
      return signed_mag((n < 0) != (d < 0), (abs_w(n) << FB) / ud);
   endfunction

   function automatic longint fx_const(bit neg, longint unsigned num, longint unsigned den);
      longint unsigned q;
      q = (num << (FB + 1)) / den;
      return signed_mag(neg, (q + 1) >> 1);
   endfunction

   function automatic longint lat_to_y(longint t);
      longint t2, t4, s;
      t2 = fx_mul(t, t);
      t4 = fx_mul(t2, t2);
      s = clamp_w(fx_const(1, 14499, 100000) + fx_mul(fx_const(0, 2406, 100000), t2));
      s = clamp_w(fx_const(0, 23185, 100000) + fx_mul(t2, s));
      return fx_mul(t, clamp_w(fx_const(0, 10148, 10000) + fx_mul(t4, s)));
   endfunction

   function automatic longint lat_to_slope(longint t);
      longint t2, t4, s;
      t2 = fx_mul(t, t);
      t4 = fx_mul(t2, t2);
      s = clamp_w(fx_const(1, 101493, 100000) + fx_mul(fx_const(0, 21654, 100000), t2));
      s = clamp_w(fx_const(0, 115925, 100000) + fx_mul(t2, s));
      return clamp_w(fx_const(0, 10148, 10000) + fx_mul(t4, s));
   endfunction

   function automatic point_rsp_type project_point(point_req_type r);
      point_rsp_type o;
      longint     ymax, yt, yc, corr;
      bit         done;
      o.res_a = r.coord_a;
      o.flag  = 1'b0;
      if (r.opcode == OPC_FORWARD) begin
         o.res_b = DW'(lat_to_y(longint'(r.coord_b)));
      end else begin
         ymax = fx_const(0, 1790857183, 1000000000);
         yt = longint'(r.coord_b);
         if (yt > ymax) yt = ymax;
         else if (yt < -ymax) yt = -ymax;
         yc = yt;
         done = 1'b0;
         for (int i = 0; i < int'(iter_max) && !done; i++) begin
            corr = fx_div(clamp_w(lat_to_y(yc) - yt), lat_to_slope(yc));
            yc = clamp_w(yc - corr);
            if (abs_w(corr) < longint'(step_tol)) done = 1'b1;
         end
         o.res_b = DW'(yc);
         o.flag  = !done;
      end
      return o;
   endfunction

   // ---------------- driver ----------------
   always @(negedge clock) begin : drive_requests
      point_req_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (pending_q.size() > 0 && (no_idle || $urandom_range(99) >= 34)) begin
            it = pending_q.pop_front();
            req_valid   <= 1'b1;
            req_opcode  <= it.opcode;
            req_coord_a <= it.coord_a;
            req_coord_b <= it.coord_b;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : drive_ready
      if (hold_req) begin
         hold_left = 400;
         hold_req  = 1'b0;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= no_idle || $urandom_range(99) >= 34;
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin : watch
      point_req_type r;
      point_rsp_type e;
      n_cycles = n_cycles + 1;
      if (n_cycles > CYCLE_LIMIT) begin
         $display("[cylindrical_projection_unit] ERROR");
         $finish;
      end else if (!reset) begin
         if (req_valid && req_ready) begin
            r.opcode  = req_opcode;
            r.coord_a = req_coord_a;
            r.coord_b = req_coord_b;
            projected_q.push_back(project_point(r));
            n_accepted = n_accepted + 1;
            req_taken  = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (projected_q.size() == 0) begin
               $display("%0t: response with no request pending: a=%0d b=%0d nc=%0b",
                        $time, rsp_result_a, rsp_result_b, rsp_not_converged);
               n_errors = n_errors + 1;
            end else begin
               e = projected_q.pop_front();
               if (rsp_result_a !== e.res_a) begin
                  $display("%0t: result_a expected %0d actual %0d", $time, e.res_a,
                           rsp_result_a);
                  n_errors = n_errors + 1;
               end
               if (rsp_result_b !== e.res_b) begin
                  $display("%0t: result_b expected %0d actual %0d", $time, e.res_b,
                           rsp_result_b);
                  n_errors = n_errors + 1;
               end
               if (rsp_not_converged !== e.flag) begin
                  $display("%0t: not_converged expected %0b actual %0b", $time, e.flag,
                           rsp_not_converged);
                  n_errors = n_errors + 1;
               end
            end
         end
      end
   end

   // ---------------- stimulus ----------------
   task automatic add_point(logic op, logic signed [DW-1:0] a, logic signed [DW-1:0] b);
      point_req_type it;
      it.opcode  = op;
      it.coord_a = a;
      it.coord_b = b;
      pending_q.push_back(it);
      n_queued = n_queued + 1;
   endtask

   // Mostly plausible coordinates, with some full-range words to hit saturation.
   task automatic add_random(int count);
      logic signed [DW-1:0] b;
      logic                 op;
      for (int i = 0; i < count; i++) begin
         op = 1'($urandom_range(1));
         case ($urandom_range(9))
            0, 1:    b = $urandom;
            2:       b = $urandom_range(16) - 8;
            default: b = $urandom_range(960000000) - 480000000;
         endcase
         add_point(op, $urandom, b);
      end
   endtask

   task automatic wait_drained();
      wait (n_accepted == n_queued && projected_q.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_regs(logic [7:0] lim, logic [7:0] tol);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_ITER_LIMIT;
      csr_wdata <= lim;
      @(negedge clock);
      csr_index <= CSR_STEP_TOL;
      csr_wdata <= tol;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      iter_max = lim;
      step_tol = tol;
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_opcode  = OPC_FORWARD;
      req_coord_a = '0;
      req_coord_b = '0;
      rsp_ready   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_ITER_LIMIT;
      csr_wdata   = '0;
      n_queued    = 0;
      n_accepted  = 0;
      n_errors    = 0;
      n_cycles    = 0;
      req_taken   = 1'b0;
      no_idle     = 1'b0;
      hold_req    = 1'b0;
      hold_left   = 0;
      iter_max    = ITER_LIMIT_RESET;
      step_tol    = STEP_TOL_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed points under the reset register values.
      add_point(OPC_FORWARD, 0, 0);
      add_point(OPC_FORWARD, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
      add_point(OPC_FORWARD, 32'sh80000000, 32'sh80000000);
      add_point(OPC_FORWARD, 1, -1);
      add_point(OPC_FORWARD, -1, 421657428);
      add_point(OPC_FORWARD, 12345, -421657428);
      add_point(OPC_FORWARD, 0, 600000000);
      add_point(OPC_INVERSE, 0, 0);
      add_point(OPC_INVERSE, 32'sh7FFFFFFF, 480722637);
      add_point(OPC_INVERSE, 32'sh80000000, -480722637);
      add_point(OPC_INVERSE, 5, 32'sh7FFFFFFF);
      add_point(OPC_INVERSE, -5, 32'sh80000000);
      add_point(OPC_INVERSE, 0, 480722700);
      add_point(OPC_INVERSE, 0, 1);
      add_point(OPC_INVERSE, 0, -1);
      add_point(OPC_INVERSE, 0, 268435456);
      add_point(OPC_INVERSE, 0, -300000000);
      wait_drained();

      // A stretch with no idling on either side.
      no_idle = 1'b1;
      add_random(300);
      wait_drained();
      no_idle = 1'b0;
      add_random(400);
      wait_drained();

      set_regs(8'd255, 8'd1);
      add_random(100);
      wait_drained();

      set_regs(8'd1, 8'd1);
      add_random(200);
      wait_drained();

      // Responses are held off while requests keep coming, so the unit backs up.
      set_regs(8'd20, 8'd3);
      hold_req = 1'b1;
      add_random(400);
      wait_drained();

      set_regs(8'd8, 8'd255);
      add_random(300);
      wait_drained();

      set_regs(8'd3, 8'd128);
      add_random(250);
      wait_drained();

      if (n_errors == 0) begin
         $display("[cylindrical_projection_unit] OK");
      end else begin
         $display("[cylindrical_projection_unit] ERROR");
      end
      $finish;
   end

endmodule

/* cylindrical_projection_unit.f */
rtl/cylproj_pkg.sv
rtl/cylproj_mul.sv
rtl/cylproj_div.sv
rtl/cylindrical_projection_unit.sv
tb/tb_cylindrical_projection_unit.sv
